@@ rtl/core/utf8d_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, job and status types, and lead-byte decoding for the UTF-8 decoder.
// Depends on nothing; every other file of the decoder imports it.
package utf8d_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CP_W        = 21;
  localparam int unsigned REP_W       = 3;   // holds 0 to 4 replacements
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CP_W-1:0] REPLACEMENT_CP = CP_W'(32'hFFFD);
  localparam logic [CP_W-1:0] MAX_CP         = CP_W'(32'h10FFFF);
  localparam logic [CP_W-1:0] SURR_LO        = CP_W'(32'hD800);
  localparam logic [CP_W-1:0] SURR_HI        = CP_W'(32'hDFFF);
  localparam logic [CP_W-1:0] MIN_CP_2B      = CP_W'(32'h80);
  localparam logic [CP_W-1:0] MIN_CP_3B      = CP_W'(32'h800);
  localparam logic [CP_W-1:0] MIN_CP_4B      = CP_W'(32'h10000);

  typedef enum logic [1:0] {
    LEAD_ASCII = 2'd0,
    LEAD_SEQ   = 2'd1,
    LEAD_BAD   = 2'd2
  } lead_kind_e;

  typedef struct packed {
    lead_kind_e      kind;
    logic [1:0]      need;
    logic [CP_W-1:0] bits;
  } lead_info_t;

  // Work for one input byte: a run of replacements, then optionally one decoded value.
  typedef struct packed {
    logic [REP_W-1:0] n_rep;
    logic             has_tail;
    logic [CP_W-1:0]  tail_cp;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_head_t;

  function automatic lead_info_t lead_decode(input logic [BYTE_W-1:0] b);
    lead_info_t li;
    li.kind = LEAD_BAD;
    li.need = 2'd0;
    li.bits = '0;
    if (b inside {[8'h00:8'h7F]}) begin
      li.kind = LEAD_ASCII;
      li.bits = CP_W'(b);
    end else if (b inside {[8'hC0:8'hDF]}) begin
      li.kind = LEAD_SEQ;
      li.need = 2'd1;
      li.bits = CP_W'(b & 8'h1F);
    end else if (b inside {[8'hE0:8'hEF]}) begin
      li.kind = LEAD_SEQ;
      li.need = 2'd2;
      li.bits = CP_W'(b & 8'h0F);
    end else if (b inside {[8'hF0:8'hF7]}) begin
      li.kind = LEAD_SEQ;
      li.need = 2'd3;
      li.bits = CP_W'(b & 8'h07);
    end
    return li;
  endfunction

  function automatic logic [CP_W-1:0] min_cp(input logic [1:0] need);
    logic [CP_W-1:0] m;
    case (need)
      2'd1:    m = MIN_CP_2B;
      2'd2:    m = MIN_CP_3B;
      default: m = MIN_CP_4B;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/core/utf8d_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the byte input and the code point output.
// Depends on utf8d_pkg for the field widths.
interface utf8d_in_if;
  import utf8d_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_value;
  logic              end_of_text;

  modport source (output valid, output byte_value, output end_of_text, input ready);
  modport sink   (input valid, input byte_value, input end_of_text, output ready);
endinterface

interface utf8d_out_if;
  import utf8d_pkg::*;
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;
  logic            is_replacement;
  logic            last_of_run;

  modport source (output valid, output code_point, output is_replacement,
                  output last_of_run, input ready);
  modport sink   (input valid, input code_point, input is_replacement,
                  input last_of_run, output ready);
endinterface

@@ rtl/core/utf8d_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts bytes, tracks the pending sequence and turns each byte that causes results into a job.
// Depends on utf8d_pkg and utf8d_if.
module utf8d_front
  import utf8d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  utf8d_in_if.sink    in_i,
  input  logic        q_full_i,
  output logic        push_o,
  output job_t        job_o
);

  logic [1:0]      exp_q, exp_d;
  logic [1:0]      seen_q, seen_d;
  logic [CP_W-1:0] part_q, part_d;

  logic            accept;
  logic            is_cont;
  lead_info_t      li;
  logic [REP_W-1:0] base_rep;
  logic [REP_W-1:0] seen_n;
  logic            do_lead;
  logic [CP_W-1:0] pv;
  logic [1:0]      exp_n, seen_nx;
  logic [CP_W-1:0] part_n;
  job_t            job;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign is_cont    = (in_i.byte_value[7:6] == 2'b10);
  assign li         = lead_decode(in_i.byte_value);
  assign seen_n     = REP_W'(seen_q) + REP_W'(1);
  assign pv         = {part_q[CP_W-7:0], in_i.byte_value[5:0]};

  always_comb begin
    job      = '0;
    base_rep = '0;
    do_lead  = 1'b0;
    exp_n    = exp_q;
    seen_nx  = seen_q;
    part_n   = part_q;

    if (exp_q == 2'd0) begin
      do_lead = 1'b1;
    end else if (is_cont) begin
      if (seen_n >= REP_W'(exp_q)) begin
        if (pv < min_cp(exp_q) || pv > MAX_CP || (pv >= SURR_LO && pv <= SURR_HI)) begin
          job.n_rep = REP_W'(1) + REP_W'(exp_q);
        end else begin
          job.has_tail = 1'b1;
          job.tail_cp  = pv;
        end
        exp_n   = 2'd0;
        seen_nx = 2'd0;
        part_n  = '0;
      end else if (in_i.end_of_text) begin
        job.n_rep = REP_W'(1) + seen_n;
        exp_n     = 2'd0;
        seen_nx   = 2'd0;
        part_n    = '0;
      end else begin
        seen_nx = seen_n[1:0];
        part_n  = pv;
      end
    end else begin
      // Broken sequence: one replacement for the lead and each gathered byte.
      base_rep  = REP_W'(1) + REP_W'(seen_q);
      job.n_rep = base_rep;
      exp_n     = 2'd0;
      seen_nx   = 2'd0;
      part_n    = '0;
      do_lead   = 1'b1;
    end

    if (do_lead) begin
      case (li.kind)
        LEAD_ASCII: begin
          job.has_tail = 1'b1;
          job.tail_cp  = li.bits;
        end
        LEAD_SEQ: begin
          if (in_i.end_of_text) begin
            job.n_rep = base_rep + REP_W'(1);
          end else begin
            exp_n   = li.need;
            seen_nx = 2'd0;
            part_n  = li.bits;
          end
        end
        default: begin
          job.n_rep = base_rep + REP_W'(1);
        end
      endcase
    end
  end

  assign exp_d  = accept ? exp_n   : exp_q;
  assign seen_d = accept ? seen_nx : seen_q;
  assign part_d = accept ? part_n  : part_q;
  assign push_o = accept && (job.n_rep != '0 || job.has_tail);
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q  <= 2'd0;
      seen_q <= 2'd0;
      part_q <= '0;
    end else begin
      exp_q  <= exp_d;
      seen_q <= seen_d;
      part_q <= part_d;
    end
  end

  a_seen_below_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_q != 2'd0 |-> seen_q < exp_q)
    else $error("gathered count reached the sequence length while still pending");

  a_idle_part_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_q == 2'd0 |-> part_q == '0)
    else $error("partial value left over with no sequence pending");

endmodule

@@ rtl/core/utf8d_queue.sv @@
`timescale 1ns / 1ps
// Short show-ahead job queue between the front end and the result expander.
// Depends on utf8d_pkg.
module utf8d_queue
  import utf8d_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  job_t    job_i,
  input  logic    pop_i,
  output logic    full_o,
  output q_head_t head_o
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_pop;

  assign full_o      = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.job   = mem_q[rd_ptr_q];
  assign do_pop      = pop_i && head_o.valid;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (!push_i && do_pop) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job written into a full queue");

endmodule

@@ rtl/core/utf8d_back.sv @@
`timescale 1ns / 1ps
// Back end: expands the head job into results in an output register, one per cycle unless stalled.
// Depends on utf8d_pkg and utf8d_if.
module utf8d_back
  import utf8d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  q_head_t     head_i,
  output logic        pop_o,
  utf8d_out_if.source out_o
);

  logic [1:0]       idx_q, idx_d;
  logic             valid_q, valid_d;
  logic [CP_W-1:0]  cp_q, cp_d;
  logic             rep_q, rep_d;
  logic             last_q, last_d;

  logic [REP_W-1:0] total;
  logic [REP_W-1:0] idx_ext;
  logic             load;
  logic             is_rep;
  logic             is_last;

  assign total   = head_i.job.n_rep + REP_W'(head_i.job.has_tail);
  assign idx_ext = REP_W'(idx_q);
  assign is_rep  = idx_ext < head_i.job.n_rep;
  assign is_last = (idx_ext + REP_W'(1)) == total;
  assign load    = head_i.valid && (!valid_q || out_o.ready);
  assign pop_o   = load && is_last;

  always_comb begin
    valid_d = valid_q;
    cp_d    = cp_q;
    rep_d   = rep_q;
    last_d  = last_q;
    idx_d   = idx_q;
    if (load) begin
      valid_d = 1'b1;
      cp_d    = is_rep ? REPLACEMENT_CP : head_i.job.tail_cp;
      rep_d   = is_rep;
      last_d  = is_last;
      idx_d   = is_last ? 2'd0 : idx_q + 2'd1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_q   <= cp_d;
    rep_q  <= rep_d;
    last_q <= last_d;
  end

  assign out_o.valid          = valid_q;
  assign out_o.code_point     = cp_q;
  assign out_o.is_replacement = rep_q;
  assign out_o.last_of_run    = last_q;

  a_job_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_i.valid |-> total != '0)
    else $error("queued job carries no results");

  a_mid_job_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 2'd0 |-> head_i.valid)
    else $error("job left the queue before all its results were sent");

endmodule

@@ rtl/core/utf8_validating_decoder.sv @@
`timescale 1ns / 1ps
// Top level of the validating UTF-8 decoder: front end, job queue and result expander.
// Depends on utf8d_pkg, utf8d_if, utf8d_front, utf8d_queue and utf8d_back.
//
// Usage:
//   in_i carries one byte of UTF-8 text per transaction, with end_of_text set on
//   the final byte. out_o carries decoded code points; a malformed sequence gives
//   0xFFFD with is_replacement set, one for the lead byte and one for each
//   continuation byte already taken. Each byte causes zero to four results, and
//   last_of_run marks the final result caused by a given byte. A byte that opens
//   or extends a sequence which then stays open causes no result but the replacements for any sequence it breaks.
// Path: a byte's job is written into the job queue, then loaded from the queue head
//   into the output register that drives out_o; while that register holds a stalled
//   transaction, the load waits.
// Throughput: one byte per cycle is accepted while the four-entry job queue has
//   room; the output side sends one result per cycle while out_o.ready is high,
//   and the queue absorbs the difference when a byte causes several results.
// Reset: rst_ni clears the pending sequence, empties the queue and drops
//   out_o.valid; bytes are accepted from the first cycle after reset.
// Stalls: when out_o.ready is low the output register holds its transaction;
//   the front end keeps decoding until the queue fills, then drops in_i.ready.
module utf8_validating_decoder
  import utf8d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  utf8d_in_if.sink    in_i,
  utf8d_out_if.source out_o
);

  logic    q_full;
  logic    push;
  job_t    job;
  logic    pop;
  q_head_t head;

  // Classifies every accepted byte and updates the pending-sequence state.
  utf8d_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (job)
  );

  // Decouples the byte side from the result side.
  utf8d_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .pop_i  (pop),
    .full_o (q_full),
    .head_o (head)
  );

  // Sends the results of the head job, one per cycle while out_o.ready is high.
  utf8d_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule
